@@ src/cct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_pkg: shared types and helpers for the calendar clock
// Beat layouts, calendar constants, month length and leap-year check.
// ----------------------------------------------------------------------------
package cct_pkg;

    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [13:0] FALLBACK_YEAR = 14'd2017;
    localparam logic [3:0]  MONTH_FIRST   = 4'd1;
    localparam logic [3:0]  MONTH_LAST    = 4'd12;
    localparam logic [4:0]  DAY_FIRST     = 5'd1;
    localparam logic [4:0]  HOUR_LAST     = 5'd23;
    localparam logic [4:0]  HOUR_NOON     = 5'd12;
    localparam logic [5:0]  MINUTE_LAST   = 6'd59;
    localparam logic [5:0]  SECOND_LAST   = 6'd59;

    // Reciprocal of 25 scaled by 2^17, exact for every 14-bit year
    localparam logic [12:0] RECIP_25      = 13'd5243;
    localparam int          RECIP_SHIFT   = 17;

    // Beat kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Month codes with a short month
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    typedef struct packed {
        logic        kind;
        logic [13:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_in;

    typedef struct packed {
        logic [13:0] cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [3:0]  hour_twelve;
        logic        is_pm;
        logic        date_fixed;
        logic        time_fixed;
    } t_out;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    // Leap when divisible by 4 and not by 100, or divisible by 400.
    // With 100 = 4 * 25 and 400 = 16 * 25 only a divisibility test by 25 is needed.
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic [9:0]  quo;
        logic [14:0] back;
        logic        div25;
        prod  = 27'(y) * 27'(RECIP_25);
        quo   = prod[26:RECIP_SHIFT];
        back  = (15'(quo) << 4) + (15'(quo) << 3) + 15'(quo);
        div25 = (back == {1'b0, y});
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB:                            len = leap ? 5'd29 : 5'd28;
            default:                            len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

@@ src/cct_next.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_next: next calendar state for one beat
// Tick carry chain or checked load, plus the result fields.
// ----------------------------------------------------------------------------
module cct_next (
    input  cct_pkg::t_in   i_beat,
    input  cct_pkg::t_time i_cur,
    output cct_pkg::t_time o_next,
    output cct_pkg::t_out  o_res
);

    logic [13:0] leap_year;
    logic        leap;
    logic [4:0]  mon_len;
    logic        date_ok;
    logic        time_ok;
    logic        sec_wrap;
    logic        min_wrap;
    logic        hour_wrap;
    logic        month_wrap;
    logic        year_wrap;
    cct_pkg::t_time tick_t;
    cct_pkg::t_time load_t;
    cct_pkg::t_time nxt;

    // One leap check serves both paths
    assign leap_year = (i_beat.kind == cct_pkg::KIND_LOAD) ? i_beat.load_year : i_cur.year;
    assign leap      = cct_pkg::is_leap(leap_year);
    assign mon_len   = cct_pkg::month_days((i_beat.kind == cct_pkg::KIND_LOAD) ?
                                           i_beat.load_month : i_cur.month, leap);

    // Tick: ripple the carry up through the fields
    always_comb begin
        sec_wrap   = (i_cur.second >= cct_pkg::SECOND_LAST);
        min_wrap   = sec_wrap && (i_cur.minute >= cct_pkg::MINUTE_LAST);
        hour_wrap  = min_wrap && (i_cur.hour >= cct_pkg::HOUR_LAST);
        month_wrap = hour_wrap && (i_cur.day >= mon_len);
        year_wrap  = month_wrap && (i_cur.month >= cct_pkg::MONTH_LAST);

        tick_t = i_cur;
        tick_t.second = sec_wrap ? 6'd0 : i_cur.second + 6'd1;
        if (sec_wrap) begin
            tick_t.minute = min_wrap ? 6'd0 : i_cur.minute + 6'd1;
        end
        if (min_wrap) begin
            tick_t.hour = hour_wrap ? 5'd0 : i_cur.hour + 5'd1;
        end
        if (hour_wrap) begin
            tick_t.day = month_wrap ? cct_pkg::DAY_FIRST : i_cur.day + 5'd1;
        end
        if (month_wrap) begin
            tick_t.month = year_wrap ? cct_pkg::MONTH_FIRST : i_cur.month + 4'd1;
        end
        if (year_wrap) begin
            tick_t.year = (i_cur.year >= cct_pkg::YEAR_MAX) ? 14'd0 : i_cur.year + 14'd1;
        end
    end

    // Load: check date and time independently, fall back on failure
    always_comb begin
        date_ok = (i_beat.load_year <= cct_pkg::YEAR_MAX)
               && (i_beat.load_month >= cct_pkg::MONTH_FIRST)
               && (i_beat.load_month <= cct_pkg::MONTH_LAST)
               && (i_beat.load_day >= cct_pkg::DAY_FIRST)
               && (i_beat.load_day <= mon_len);
        time_ok = (i_beat.load_hour <= cct_pkg::HOUR_LAST)
               && (i_beat.load_minute <= cct_pkg::MINUTE_LAST)
               && (i_beat.load_second <= cct_pkg::SECOND_LAST);

        load_t.year   = date_ok ? i_beat.load_year  : cct_pkg::FALLBACK_YEAR;
        load_t.month  = date_ok ? i_beat.load_month : cct_pkg::MONTH_FIRST;
        load_t.day    = date_ok ? i_beat.load_day   : cct_pkg::DAY_FIRST;
        load_t.hour   = time_ok ? i_beat.load_hour   : 5'd0;
        load_t.minute = time_ok ? i_beat.load_minute : 6'd0;
        load_t.second = time_ok ? i_beat.load_second : 6'd0;
    end

    always_comb begin
        nxt = (i_beat.kind == cct_pkg::KIND_LOAD) ? load_t : tick_t;

        o_res.cur_year    = nxt.year;
        o_res.cur_month   = nxt.month;
        o_res.cur_day     = nxt.day;
        o_res.cur_hour    = nxt.hour;
        o_res.cur_minute  = nxt.minute;
        o_res.cur_second  = nxt.second;
        o_res.hour_twelve = (nxt.hour <= cct_pkg::HOUR_NOON) ? nxt.hour[3:0]
                                                             : 4'(nxt.hour - cct_pkg::HOUR_NOON);
        o_res.is_pm       = (nxt.hour >= cct_pkg::HOUR_NOON);
        o_res.date_fixed  = (i_beat.kind == cct_pkg::KIND_LOAD) && !date_ok;
        o_res.time_fixed  = (i_beat.kind == cct_pkg::KIND_LOAD) && !time_ok;
    end

    assign o_next = nxt;

endmodule

@@ src/calendar_clock_tick.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_clock_tick: seconds real-time clock with Gregorian calendar
// Ticks advance the time by one second; loads set a checked date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one beat per
//   item: a tick (kind 0) or a load (kind 1, load fields used). Output
//   channel (o_out_valid / i_out_ready / o_out_data) returns exactly one
//   beat per item with the calendar after that item, the 12-hour hour, the
//   PM flag and, for loads, the fallback flags.
//   Path: an accepted beat is held in the input register, then goes through
//   the carry chain and load check into the calendar and result registers,
//   which drive o_out_valid and the result. One beat is taken every cycle
//   while the receiver keeps up; the single pass through the carry chain and
//   shared leap check sets that rate.
//   Reset (synchronous, active low) sets the calendar to 2017/01/01 00:00:00
//   and drops both stages.
//   When the receiver stalls, hold the result; the input register still
//   takes one more beat, then o_in_ready falls until the result is taken.
// ----------------------------------------------------------------------------
module calendar_clock_tick (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cct_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output cct_pkg::t_out o_out_data
);

    logic           r_in_valid;
    cct_pkg::t_in   r_in;
    logic           r_out_valid;
    cct_pkg::t_out  r_out;
    cct_pkg::t_time r_time;
    cct_pkg::t_time n_time;
    cct_pkg::t_out  n_out;
    logic           advance;

    // Result stage moves when empty or when its beat is being taken
    assign advance    = !r_out_valid || i_out_ready;
    // Input stage takes a beat when empty or when it hands on this cycle
    assign o_in_ready = !r_in_valid || advance;

    cct_next u_next (
        .i_beat (r_in),
        .i_cur  (r_time),
        .o_next (n_time),
        .o_res  (n_out)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Calendar state and result register advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_time.year   <= cct_pkg::FALLBACK_YEAR;
            r_time.month  <= cct_pkg::MONTH_FIRST;
            r_time.day    <= cct_pkg::DAY_FIRST;
            r_time.hour   <= 5'd0;
            r_time.minute <= 6'd0;
            r_time.second <= 6'd0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_time <= n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/cct_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cct_checker: port-level checks for the calendar clock
// Output handshake and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module cct_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input cct_pkg::t_out o_out_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_fields_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.cur_year <= cct_pkg::YEAR_MAX)
                     && (o_out_data.cur_month >= cct_pkg::MONTH_FIRST)
                     && (o_out_data.cur_month <= cct_pkg::MONTH_LAST)
                     && (o_out_data.cur_day >= cct_pkg::DAY_FIRST)
                     && (o_out_data.cur_hour <= cct_pkg::HOUR_LAST)
                     && (o_out_data.cur_minute <= cct_pkg::MINUTE_LAST)
                     && (o_out_data.cur_second <= cct_pkg::SECOND_LAST))
        else $error("calendar field out of range");

    a_pm_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_pm == (o_out_data.cur_hour >= cct_pkg::HOUR_NOON)))
        else $error("PM flag disagrees with hour");

    a_date_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.date_fixed |->
            (o_out_data.cur_year == cct_pkg::FALLBACK_YEAR)
            && (o_out_data.cur_month == cct_pkg::MONTH_FIRST)
            && (o_out_data.cur_day == cct_pkg::DAY_FIRST))
        else $error("date fallback flagged without fallback date");

    a_time_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.time_fixed |->
            (o_out_data.cur_hour == 5'd0) && (o_out_data.cur_minute == 6'd0)
            && (o_out_data.cur_second == 6'd0))
        else $error("time fallback flagged without midnight");

endmodule

bind calendar_clock_tick cct_checker u_cct_checker (.*);
